### design/ssag_pkg.sv
`default_nettype none
package ssag_pkg;

    localparam int IDX_W  = 16;
    localparam int ADDR_W = 32;
    localparam int STR_W  = 24;
    localparam int CNT_W  = 21;
    localparam int CFG_W  = 32;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BEGIN = 2'd1;
    localparam logic [1:0] CMD_NEXT  = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_ZERO_STEP = 2'd1;
    localparam logic [1:0] STAT_BAD_RANGE = 2'd2;
    localparam logic [1:0] STAT_INACTIVE  = 2'd3;

    localparam logic [2:0] CFG_SLICE_DIMS   = 3'd0;
    localparam logic [2:0] CFG_RUN_ELEMENTS = 3'd1;
    localparam logic [2:0] CFG_ITEM_BYTES   = 3'd2;
    localparam logic [2:0] CFG_SRC_BASE     = 3'd3;
    localparam logic [2:0] CFG_DST_BASE     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_ADV,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]              command;
        logic [1:0]              dim_index;
        logic signed [IDX_W-1:0] start_index;
        logic signed [IDX_W-1:0] stop_index;
        logic signed [IDX_W-1:0] step_value;
        logic [STR_W-1:0]        stride_bytes;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_address;
        logic [CNT_W-1:0]  byte_count;
        logic              last;
        logic [IDX_W-1:0]  extent;
        logic [1:0]        status;
    } t_out_item;

endpackage
`default_nettype wire

### design/strided_slice_address_generator.sv
// Strided slice address generator.
// Input channel (i_in_valid / o_in_stall, payload i_in_data) takes one command per
// transaction: load a dimension descriptor, begin a slice walk, or emit the next copy run.
// Output channel (o_out_valid / i_out_stall, payload o_out_data) returns exactly one
// result transaction per command, held in an output register until it is taken.
// Configuration registers are written through i_cfg_we / i_cfg_index / i_cfg_data.
// Work per command, from acceptance to the result entering the output register:
//   load            a restoring divider produces one extent bit per cycle
//   begin, rejected or unknown commands, next without a walk: straight to the response
//   next            one shared multiplier forms one stride product per cycle, then the
//                   odometer carries through one dimension per cycle.
// The block takes a new command only when the previous one has finished, at the earliest
// in the cycle after its result enters the output register; o_in_stall stays high meanwhile.
// A synchronous active-low reset clears all descriptors, indices and the walk, and
// returns the configuration registers to their defaults. While the receiver stalls, a
// finished result waits in the output register; the block may accept and work on the
// next command, but holds its result until the output register is free.
`default_nettype none
module strided_slice_address_generator
    import ssag_pkg::*;
#(
    parameter int MAX_DIMS = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output      logic             o_in_stall,
    input  wire t_in_item         i_in_data,
    output      logic             o_out_valid,
    input  wire logic             i_out_stall,
    output      t_out_item        o_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CW = $clog2(MAX_DIMS + 2);

    // Configuration registers
    logic [2:0]        r_slice_dims;
    logic [16:0]       r_run_elements;
    logic [4:0]        r_item_bytes;
    logic [ADDR_W-1:0] r_src_base;
    logic [ADDR_W-1:0] r_dst_base;

    // Dimension descriptors and walk state
    logic signed [IDX_W-1:0] r_dim_start  [MAX_DIMS];
    logic signed [IDX_W-1:0] r_dim_stop   [MAX_DIMS];
    logic signed [IDX_W-1:0] r_dim_step   [MAX_DIMS];
    logic [STR_W-1:0]        r_dim_stride [MAX_DIMS];
    logic                    r_dim_back   [MAX_DIMS];
    logic                    r_dim_valid  [MAX_DIMS];
    logic signed [IDX_W-1:0] r_cur_idx    [MAX_DIMS];
    logic [31:0]             r_copied;
    logic                    r_walk_active;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt;
    logic [4:0]        r_bit;
    logic [16:0]       r_rem;
    logic [16:0]       r_quo;
    logic [16:0]       r_div;
    logic [ADDR_W-1:0] r_src;
    t_out_item         r_res;
    t_out_item         r_out;
    logic              r_out_valid;

    logic          w_in_acc;
    logic          w_out_free;
    logic [CW-1:0] w_nd;
    logic [16:0]   w_re;
    logic [4:0]    w_ib;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Register values are saturated into their legal ranges where they are used.
    always_comb begin
        if (r_slice_dims == 3'd0) begin
            w_nd = CW'(1);
        end else if (int'(r_slice_dims) > MAX_DIMS) begin
            w_nd = CW'(MAX_DIMS);
        end else begin
            w_nd = CW'(r_slice_dims);
        end
        if (r_run_elements == 17'd0) begin
            w_re = 17'd1;
        end else if (r_run_elements > 17'd65536) begin
            w_re = 17'd65536;
        end else begin
            w_re = r_run_elements;
        end
        if (r_item_bytes == 5'd0) begin
            w_ib = 5'd1;
        end else if (r_item_bytes > 5'd16) begin
            w_ib = 5'd16;
        end else begin
            w_ib = r_item_bytes;
        end
    end

    // Load decode
    logic              w_ld_dim_ok;
    logic              w_ld_zero;
    logic              w_ld_range;
    logic              w_ld_ok;
    logic [DW-1:0]     w_ld_dim;
    logic signed [16:0] w_st17, w_sp17, w_sg17;
    logic [16:0]       w_span;
    logic [16:0]       w_mag;
    logic [16:0]       w_num;

    assign w_ld_dim    = DW'(i_in_data.dim_index);
    assign w_ld_dim_ok = int'(i_in_data.dim_index) < MAX_DIMS;
    assign w_st17      = 17'(i_in_data.start_index);
    assign w_sp17      = 17'(i_in_data.stop_index);
    assign w_sg17      = 17'(i_in_data.step_value);
    assign w_ld_zero   = (i_in_data.step_value == '0);
    assign w_ld_range  = (!i_in_data.step_value[IDX_W-1] && !w_ld_zero && w_st17 > w_sp17) ||
                         (i_in_data.step_value[IDX_W-1] && w_sp17 > w_st17);
    assign w_ld_ok     = w_ld_dim_ok && !w_ld_zero && !w_ld_range;
    assign w_span      = i_in_data.step_value[IDX_W-1] ? 17'(w_st17 - w_sp17)
                                                       : 17'(w_sp17 - w_st17);
    assign w_mag       = i_in_data.step_value[IDX_W-1] ? 17'(-w_sg17) : 17'(w_sg17);
    assign w_num       = 17'(w_span + w_mag - 17'd1);

    // Begin check over the sliced dimensions
    logic w_all_valid;
    always_comb begin
        w_all_valid = 1'b1;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if ((d < int'(w_nd)) && !r_dim_valid[d]) begin
                w_all_valid = 1'b0;
            end
        end
    end

    // Result fields that are known at acceptance; everything else starts at zero.
    t_out_item w_acc_res;
    always_comb begin
        w_acc_res = '0;
        case (i_in_data.command)
            CMD_LOAD: begin
                if (!w_ld_dim_ok) begin
                    w_acc_res.status = STAT_OK;
                end else if (w_ld_zero) begin
                    w_acc_res.status = STAT_ZERO_STEP;
                end else if (w_ld_range) begin
                    w_acc_res.status = STAT_BAD_RANGE;
                end
            end
            CMD_BEGIN: begin
                if (!w_all_valid) w_acc_res.status = STAT_INACTIVE;
            end
            CMD_NEXT: begin
                if (!r_walk_active) w_acc_res.status = STAT_INACTIVE;
            end
            default: ;
        endcase
    end

    // Divider step
    logic [16:0] w_shift;
    logic        w_ge;
    assign w_shift = {r_rem[15:0], r_quo[16]};
    assign w_ge    = (w_shift >= r_div);

    // Shared multiplier: run offset, then one stride product per dimension, then run bytes.
    logic [CW-1:0]      w_mul_sel;
    logic [DW-1:0]      w_mul_dim;
    logic signed [32:0] w_mul_a;
    logic signed [24:0] w_mul_b;
    logic signed [57:0] w_mul_p;
    logic [ADDR_W-1:0]  w_prod;

    assign w_mul_sel = CW'(r_cnt - CW'(1));
    assign w_mul_dim = w_mul_sel[DW-1:0];

    always_comb begin
        if (r_cnt == '0) begin
            w_mul_a = {1'b0, r_copied};
            w_mul_b = {20'd0, w_ib};
        end else if (r_cnt == CW'(w_nd + CW'(1))) begin
            w_mul_a = {16'd0, w_re};
            w_mul_b = {20'd0, w_ib};
        end else begin
            w_mul_a = 33'(r_cur_idx[w_mul_dim]);
            w_mul_b = {1'b0, r_dim_stride[w_mul_dim]};
        end
    end
    assign w_mul_p = w_mul_a * w_mul_b;
    assign w_prod  = w_mul_p[ADDR_W-1:0];

    // Odometer step on one dimension
    logic [DW-1:0]      w_adv_dim;
    logic signed [16:0] w_nx;
    logic               w_inside;
    assign w_adv_dim = r_cnt[DW-1:0];
    assign w_nx      = 17'(r_cur_idx[w_adv_dim]) + 17'(r_dim_step[w_adv_dim]);
    assign w_inside  = r_dim_back[w_adv_dim] ? (w_nx > 17'(r_dim_stop[w_adv_dim]))
                                             : (w_nx < 17'(r_dim_stop[w_adv_dim]));

    t_out_item w_adv_res;
    always_comb begin
        w_adv_res          = r_res;
        w_adv_res.src_addr = r_src;
        w_adv_res.last     = !w_inside && (r_cnt == '0);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.command == CMD_LOAD && w_ld_ok) begin
                        n_state = S_DIV;
                    end else if (i_in_data.command == CMD_NEXT && r_walk_active) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_DIV: begin
                if (r_bit == 5'd0) n_state = S_RESP;
            end
            S_MUL: begin
                if (r_cnt == CW'(w_nd + CW'(1))) n_state = S_ADV;
            end
            S_ADV: begin
                if (w_inside || r_cnt == '0) n_state = S_RESP;
            end
            S_RESP: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_dims   <= 3'd1;
            r_run_elements <= 17'd1;
            r_item_bytes   <= 5'd1;
            r_src_base     <= '0;
            r_dst_base     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SLICE_DIMS:   r_slice_dims   <= i_cfg_data[2:0];
                CFG_RUN_ELEMENTS: r_run_elements <= i_cfg_data[16:0];
                CFG_ITEM_BYTES:   r_item_bytes   <= i_cfg_data[4:0];
                CFG_SRC_BASE:     r_src_base     <= i_cfg_data[ADDR_W-1:0];
                CFG_DST_BASE:     r_dst_base     <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_dim_start[d]  <= '0;
                r_dim_stop[d]   <= '0;
                r_dim_step[d]   <= '0;
                r_dim_stride[d] <= '0;
                r_dim_back[d]   <= 1'b0;
                r_dim_valid[d]  <= 1'b0;
                r_cur_idx[d]    <= '0;
            end
            r_copied      <= '0;
            r_walk_active <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cnt         <= '0;
            r_bit         <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_RESP) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_res <= w_acc_res;
                        r_cnt <= '0;
                        r_src <= r_src_base;
                        case (i_in_data.command)
                            CMD_LOAD: begin
                                if (w_ld_ok) begin
                                    r_dim_start[w_ld_dim]  <= i_in_data.start_index;
                                    r_dim_stop[w_ld_dim]   <= i_in_data.stop_index;
                                    r_dim_step[w_ld_dim]   <= i_in_data.step_value;
                                    r_dim_stride[w_ld_dim] <= i_in_data.stride_bytes;
                                    r_dim_back[w_ld_dim]   <= i_in_data.step_value[IDX_W-1];
                                    r_dim_valid[w_ld_dim]  <= 1'b1;
                                    r_walk_active          <= 1'b0;
                                    r_rem <= '0;
                                    r_quo <= w_num;
                                    r_div <= w_mag;
                                    r_bit <= 5'd16;
                                end
                            end
                            CMD_BEGIN: begin
                                if (w_all_valid) begin
                                    for (int d = 0; d < MAX_DIMS; d++) begin
                                        if (d < int'(w_nd)) r_cur_idx[d] <= r_dim_start[d];
                                    end
                                    r_copied      <= '0;
                                    r_walk_active <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? 17'(w_shift - r_div) : w_shift;
                    r_quo <= {r_quo[15:0], w_ge};
                    r_bit <= 5'(r_bit - 5'd1);
                    if (r_bit == 5'd0) begin
                        r_res.extent <= {r_quo[14:0], w_ge};
                    end
                end
                S_MUL: begin
                    if (r_cnt == '0) begin
                        r_res.dst_address <= r_dst_base + w_prod;
                        r_cnt <= CW'(r_cnt + CW'(1));
                    end else if (r_cnt == CW'(w_nd + CW'(1))) begin
                        r_res.byte_count <= w_prod[CNT_W-1:0];
                        r_copied <= r_copied + {15'd0, w_re};
                        r_cnt    <= CW'(w_nd - CW'(1));
                    end else begin
                        r_src <= r_src + w_prod;
                        r_cnt <= CW'(r_cnt + CW'(1));
                    end
                end
                S_ADV: begin
                    r_res <= w_adv_res;
                    if (w_inside) begin
                        r_cur_idx[w_adv_dim] <= w_nx[IDX_W-1:0];
                    end else if (r_cnt == '0) begin
                        // The outermost dimension has run out: the walk is complete.
                        r_walk_active <= 1'b0;
                    end else begin
                        r_cur_idx[w_adv_dim] <= r_dim_start[w_adv_dim];
                        r_cnt <= CW'(r_cnt - CW'(1));
                    end
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_bit <= 5'd16))
        else $error("divider bit counter out of range");

    a_next_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.command == CMD_NEXT && !r_walk_active) |=> (r_state == S_RESP))
        else $error("next without a walk must answer at once");

    a_last_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_res.last) |-> !r_walk_active)
        else $error("final run issued while the walk is still active");

    a_mul_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cnt <= CW'(w_nd + CW'(1))))
        else $error("multiplier step counter beyond the sliced dimensions");
`endif

endmodule
`default_nettype wire
